// File: design/wavhp_pkg.sv
// ---------------------------------------------------------------------------
// wavhp_pkg
// Types and constants shared by the WAV header parser files.
// ---------------------------------------------------------------------------
package wavhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_RIFX = 32'h5249_4658;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] TAG_FACT = 32'h6661_6374;

  localparam logic [15:0] FMT_PCM = 16'h0001;
  localparam logic [15:0] FMT_EXT = 16'hFFFE;

  localparam logic [31:0] GUID_W1 = 32'h0000_0001;
  localparam logic [31:0] GUID_W2 = 32'h0010_0000;
  localparam logic [31:0] GUID_W3 = 32'hAA00_0080;
  localparam logic [31:0] GUID_W4 = 32'h719B_3800;

  localparam logic [31:0] SIZE_ALL1   = 32'hFFFF_FFFF;
  localparam logic [31:0] SIZE_STREAM = 32'h7FFF_F000;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_TAG      = 4'd1;
  localparam logic [3:0] ERR_WAVE     = 4'd2;
  localparam logic [3:0] ERR_PCM_FMT  = 4'd3;
  localparam logic [3:0] ERR_EXT_BAD  = 4'd4;
  localparam logic [3:0] ERR_EXT_SUB  = 4'd5;
  localparam logic [3:0] ERR_FORMAT   = 4'd6;
  localparam logic [3:0] ERR_CHANNELS = 4'd7;
  localparam logic [3:0] ERR_BITS     = 4'd8;

  localparam int unsigned WRN_BYTERATE = 0;
  localparam int unsigned WRN_ALIGN    = 1;
  localparam int unsigned WRN_FACT     = 2;
  localparam int unsigned WRN_RIFF     = 3;

  typedef enum logic [25:0] {
    PH_FILE_TAG   = 26'd1 << 0,
    PH_RIFF_SIZE  = 26'd1 << 1,
    PH_WAVE_TAG   = 26'd1 << 2,
    PH_PRE_ID     = 26'd1 << 3,
    PH_PRE_SIZE   = 26'd1 << 4,
    PH_PRE_SKIP   = 26'd1 << 5,
    PH_FMT_SIZE   = 26'd1 << 6,
    PH_FORMAT     = 26'd1 << 7,
    PH_CHANNELS   = 26'd1 << 8,
    PH_RATE       = 26'd1 << 9,
    PH_BYTERATE   = 26'd1 << 10,
    PH_ALIGN      = 26'd1 << 11,
    PH_BITS       = 26'd1 << 12,
    PH_EXTRA_SIZE = 26'd1 << 13,
    PH_EXT_UNUSED = 26'd1 << 14,
    PH_CHANMAP    = 26'd1 << 15,
    PH_GUID1      = 26'd1 << 16,
    PH_GUID2      = 26'd1 << 17,
    PH_GUID3      = 26'd1 << 18,
    PH_GUID4      = 26'd1 << 19,
    PH_FMT_SKIP   = 26'd1 << 20,
    PH_POST_ID    = 26'd1 << 21,
    PH_POST_SIZE  = 26'd1 << 22,
    PH_POST_SKIP  = 26'd1 << 23,
    PH_DATA_SIZE  = 26'd1 << 24,
    PH_PAYLOAD    = 26'd1 << 25
  } phase_t;

  typedef enum logic [8:0] {
    SQ_IDLE = 9'd1 << 0,
    SQ_MA   = 9'd1 << 1,
    SQ_MAW  = 9'd1 << 2,
    SQ_MB   = 9'd1 << 3,
    SQ_MBW  = 9'd1 << 4,
    SQ_MC   = 9'd1 << 5,
    SQ_MCW  = 9'd1 << 6,
    SQ_DV   = 9'd1 << 7,
    SQ_DVW  = 9'd1 << 8
  } seq_t;

  typedef enum logic [0:0] {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } mdu_op_t;

  typedef struct packed {
    logic        start;
    mdu_op_t     op;
    logic [31:0] a;
    logic [15:0] b;
  } mdu_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] res;
  } mdu_rsp_t;

endpackage

// File: design/wavhp_in_if.sv
// ---------------------------------------------------------------------------
// wavhp_in_if
// Byte input channel, valid/ready.
// ---------------------------------------------------------------------------
interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// File: design/wavhp_out_if.sv
// ---------------------------------------------------------------------------
// wavhp_out_if
// Result channel, valid/ready, one transaction per input byte.
// ---------------------------------------------------------------------------
interface wavhp_out_if;
  logic               valid;
  logic               ready;
  logic               payload_valid;
  logic [7:0]         payload_byte;
  logic               payload_last;
  logic               header_done;
  logic [3:0]         error_code;
  logic [3:0]         warning_flags;
  logic               big_endian;
  logic [15:0]        num_channels;
  logic [31:0]        samp_rate;
  logic [15:0]        frame_bytes;
  logic               stream_mode;
  logic signed [32:0] sample_count;

  modport source (output valid, output payload_valid, output payload_byte,
                  output payload_last, output header_done, output error_code,
                  output warning_flags, output big_endian, output num_channels,
                  output samp_rate, output frame_bytes, output stream_mode,
                  output sample_count, input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input payload_last, input header_done, input error_code,
                input warning_flags, input big_endian, input num_channels,
                input samp_rate, input frame_bytes, input stream_mode,
                input sample_count, output ready);
endinterface

// File: design/wav_riff_header_parser_unit.sv
// For ordinary bytes the result is registered and posted in the cycle after the input transaction.
// On the last byte of the parsed fmt fields the result waits for three multiplies on the shared unit.
// On the data chunk size, non-stream with nonzero block align, it waits for a 32-step divide.
// Throughput: one byte per cycle while the result channel drains; the shared
// multiply/divide unit holds the input off only at those two header points.
// Reset: synchronous active-low rst_n clears all parser state to "expect file tag".
// ---------------------------------------------------------------------------
// wav_riff_header_parser_unit
// Byte-wise RIFF/RIFX WAVE header parser with payload pass-through.
// ---------------------------------------------------------------------------
module wav_riff_header_parser_unit
  import wavhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  wavhp_in_if.sink    in_ch,
  wavhp_out_if.source out_ch
);

  function automatic logic [3:0] set_err(input logic [3:0] cur, input logic [3:0] code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] fs_r, fs_nxt;
  logic        swap_r, swap_nxt;
  logic [31:0] riff_r, riff_nxt;
  logic [31:0] cons_r, cons_nxt;
  logic [31:0] fmtsz_r, fmtsz_nxt;
  logic [15:0] fmtid_r, fmtid_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] brate_r, brate_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [31:0] dsize_r, dsize_nxt;
  logic [31:0] prem_r, prem_nxt;
  logic [3:0]  err_r, err_nxt;
  logic [3:0]  warn_r, warn_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic        gbad_r, gbad_nxt;
  // per-transaction payload result
  logic        pv_r, pv_nxt;
  logic [7:0]  pb_r, pb_nxt;
  logic        pl_r, pl_nxt;
  // sequencer and shared unit
  seq_t        seq_r, seq_nxt;
  logic [31:0] tmp_r, tmp_nxt;
  logic [31:0] quot_r, quot_nxt;
  logic        ov_r, ov_nxt;
  mdu_req_t    mreq;
  mdu_rsp_t    mrsp;

  logic        accept;
  logic        fire_mul, fire_div;
  logic [7:0]  b;
  logic [2:0]  len;
  logic [2:0]  idx_inc;
  logic [31:0] v;
  logic        fin;
  logic [31:0] fin_len;
  logic [15:0] bits_eff;
  logic        stream_new, stream_reg;
  logic [31:0] cons4;
  logic signed [34:0] rdiff;
  logic        seq_end;

  assign b      = in_ch.data_byte;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (seq_r == SQ_IDLE) && (!ov_r || out_ch.ready);

  assign stream_reg = (riff_r == 32'd0) || (riff_r == SIZE_ALL1) || (dsize_r == 32'd0) ||
                      (dsize_r == SIZE_ALL1) || (dsize_r == SIZE_STREAM);

  // byte-level parse step
  always_comb begin
    phase_nxt = phase_r; idx_nxt = idx_r; fs_nxt = fs_r; swap_nxt = swap_r;
    riff_nxt = riff_r; cons_nxt = cons_r; fmtsz_nxt = fmtsz_r; fmtid_nxt = fmtid_r;
    chan_nxt = chan_r; rate_nxt = rate_r; brate_nxt = brate_r; align_nxt = align_r;
    bits_nxt = bits_r; skip_nxt = skip_r; dsize_nxt = dsize_r; prem_nxt = prem_r;
    err_nxt = err_r; tag_nxt = tag_r; gbad_nxt = gbad_r;
    pv_nxt = 1'b0; pb_nxt = 8'd0; pl_nxt = 1'b0;
    fire_mul = 1'b0; fire_div = 1'b0;
    fin = 1'b0; fin_len = 32'd16; bits_eff = bits_r;
    v = '0; stream_new = 1'b0; cons4 = '0; rdiff = '0;
    idx_inc = idx_r + 3'd1;

    case (phase_r)
      PH_FORMAT, PH_CHANNELS, PH_ALIGN, PH_BITS, PH_EXTRA_SIZE, PH_EXT_UNUSED: len = 3'd2;
      PH_PRE_SKIP, PH_FMT_SKIP, PH_POST_SKIP, PH_PAYLOAD: len = 3'd0;
      default: len = 3'd4;
    endcase

    if (len != 3'd0) begin
      if (phase_r == PH_FILE_TAG || phase_r == PH_WAVE_TAG || phase_r == PH_PRE_ID ||
          phase_r == PH_POST_ID || swap_r)
        v = {fs_r[23:0], b};
      else
        v = fs_r | ({24'd0, b} << {idx_r[1:0], 3'b000});
      fs_nxt  = v;
      idx_nxt = idx_inc;
      if (idx_inc >= len) begin
        fs_nxt  = '0;
        idx_nxt = '0;
        case (phase_r)
          PH_FILE_TAG: begin
            if (v == TAG_RIFF) swap_nxt = 1'b0;
            else if (v == TAG_RIFX) swap_nxt = 1'b1;
            else err_nxt = set_err(err_nxt, ERR_TAG);
            phase_nxt = PH_RIFF_SIZE;
          end
          PH_RIFF_SIZE: begin riff_nxt = v; phase_nxt = PH_WAVE_TAG; end
          PH_WAVE_TAG: begin
            if (v != TAG_WAVE) err_nxt = set_err(err_nxt, ERR_WAVE);
            cons_nxt  = 32'd4;
            phase_nxt = PH_PRE_ID;
          end
          PH_PRE_ID: begin
            cons_nxt  = cons_r + 32'd4;
            phase_nxt = (v == TAG_FMT) ? PH_FMT_SIZE : PH_PRE_SIZE;
          end
          PH_PRE_SIZE: begin
            cons_nxt  = cons_r + 32'd4 + v;
            skip_nxt  = v;
            phase_nxt = (v != 32'd0) ? PH_PRE_SKIP : PH_PRE_ID;
          end
          PH_FMT_SIZE: begin fmtsz_nxt = v; phase_nxt = PH_FORMAT; end
          PH_FORMAT:   begin fmtid_nxt = v[15:0]; phase_nxt = PH_CHANNELS; end
          PH_CHANNELS: begin chan_nxt = v[15:0]; phase_nxt = PH_RATE; end
          PH_RATE:     begin rate_nxt = v; phase_nxt = PH_BYTERATE; end
          PH_BYTERATE: begin brate_nxt = v; phase_nxt = PH_ALIGN; end
          PH_ALIGN:    begin align_nxt = v[15:0]; phase_nxt = PH_BITS; end
          PH_BITS: begin
            bits_nxt = v[15:0];
            bits_eff = v[15:0];
            if (fmtid_r == FMT_PCM) begin
              if (fmtsz_r < 32'd16) err_nxt = set_err(err_nxt, ERR_PCM_FMT);
              fin = 1'b1;
            end else if (fmtid_r == FMT_EXT) begin
              phase_nxt = PH_EXTRA_SIZE;
            end else begin
              err_nxt = set_err(err_nxt, ERR_FORMAT);
              fin = 1'b1;
            end
          end
          PH_EXTRA_SIZE: begin
            if (fmtsz_r < 32'd40 || v < 32'd22) err_nxt = set_err(err_nxt, ERR_EXT_BAD);
            gbad_nxt  = 1'b0;
            phase_nxt = PH_EXT_UNUSED;
          end
          PH_EXT_UNUSED: phase_nxt = PH_CHANMAP;
          PH_CHANMAP:    phase_nxt = PH_GUID1;
          PH_GUID1: begin if (v != GUID_W1) gbad_nxt = 1'b1; phase_nxt = PH_GUID2; end
          PH_GUID2: begin if (v != GUID_W2) gbad_nxt = 1'b1; phase_nxt = PH_GUID3; end
          PH_GUID3: begin if (v != GUID_W3) gbad_nxt = 1'b1; phase_nxt = PH_GUID4; end
          PH_GUID4: begin
            if (v != GUID_W4 || gbad_r) begin
              gbad_nxt = 1'b1;
              err_nxt  = set_err(err_nxt, ERR_EXT_SUB);
            end
            fin_len = 32'd40;
            fin     = 1'b1;
          end
          PH_POST_ID: begin
            cons_nxt  = cons_r + 32'd4;
            tag_nxt   = v;
            phase_nxt = (v == TAG_DATA) ? PH_DATA_SIZE : PH_POST_SIZE;
          end
          PH_POST_SIZE: begin
            cons_nxt  = cons_r + 32'd4 + v;
            skip_nxt  = v;
            phase_nxt = (v != 32'd0) ? PH_POST_SKIP : PH_POST_ID;
          end
          PH_DATA_SIZE: begin
            dsize_nxt  = v;
            prem_nxt   = v;
            cons4      = cons_r + 32'd4;
            cons_nxt   = cons4;
            stream_new = (riff_r == 32'd0) || (riff_r == SIZE_ALL1) || (v == 32'd0) ||
                         (v == SIZE_ALL1) || (v == SIZE_STREAM);
            rdiff      = $signed({3'b000, cons4}) + $signed({3'b000, v}) -
                         $signed({3'b000, riff_r});
            phase_nxt  = PH_PAYLOAD;
            fire_div   = !stream_new && (align_r != 16'd0);
          end
          default: phase_nxt = PH_PAYLOAD;
        endcase
        if (fin) begin
          if (chan_r == 16'd0) err_nxt = set_err(err_nxt, ERR_CHANNELS);
          if (bits_eff != 16'd16) err_nxt = set_err(err_nxt, ERR_BITS);
          cons_nxt = cons_r + 32'd4 + fmtsz_r;
          fire_mul = 1'b1;
          if (fmtsz_r > fin_len) begin
            skip_nxt  = fmtsz_r - fin_len;
            phase_nxt = PH_FMT_SKIP;
          end else begin
            phase_nxt = PH_POST_ID;
          end
        end
      end
    end else if (phase_r == PH_PAYLOAD) begin
      if (stream_reg) begin
        pv_nxt = 1'b1;
        pb_nxt = b;
      end else if (prem_r != 32'd0) begin
        pv_nxt   = 1'b1;
        pb_nxt   = b;
        pl_nxt   = (prem_r == 32'd1);
        prem_nxt = prem_r - 32'd1;
      end
    end else begin
      if (skip_r != 32'd0) skip_nxt = skip_r - 32'd1;
      if (skip_nxt == 32'd0) phase_nxt = (phase_r == PH_PRE_SKIP) ? PH_PRE_ID : PH_POST_ID;
    end
  end

  // fact-size and RIFF-size warnings come from the parse step; the byte-rate
  // and block-align warnings come back from the shared unit
  logic warn_fact, warn_riff;
  assign warn_fact = (phase_r == PH_POST_SIZE) && (len != 3'd0) && (idx_inc >= len) &&
                     (tag_r == TAG_FACT) && (v != 32'd4);
  assign warn_riff = (phase_r == PH_DATA_SIZE) && (idx_inc >= len) && !stream_new &&
                     ((rdiff > 35'sd1) || (rdiff < -35'sd1));

  // sequencer over the shared multiply/divide unit
  always_comb begin
    seq_nxt  = seq_r;
    tmp_nxt  = tmp_r;
    quot_nxt = quot_r;
    warn_nxt = warn_r;
    seq_end  = 1'b0;
    mreq     = '{start: 1'b0, op: OP_MUL, a: 32'd0, b: 16'd0};
    case (seq_r)
      SQ_IDLE: begin
        if (accept) begin
          if (warn_fact) warn_nxt[WRN_FACT] = 1'b1;
          if (warn_riff) warn_nxt[WRN_RIFF] = 1'b1;
          if (fire_mul) seq_nxt = SQ_MA;
          else if (fire_div) seq_nxt = SQ_DV;
          if (phase_r == PH_DATA_SIZE && phase_nxt == PH_PAYLOAD) quot_nxt = 32'd0;
        end
      end
      SQ_MA: begin
        mreq    = '{start: 1'b1, op: OP_MUL, a: rate_r, b: bits_r};
        seq_nxt = SQ_MAW;
      end
      SQ_MAW: if (mrsp.done) begin tmp_nxt = mrsp.res; seq_nxt = SQ_MB; end
      SQ_MB: begin
        mreq    = '{start: 1'b1, op: OP_MUL, a: {3'b000, tmp_r[31:3]}, b: chan_r};
        seq_nxt = SQ_MBW;
      end
      SQ_MBW: if (mrsp.done) begin
        if (brate_r != mrsp.res) warn_nxt[WRN_BYTERATE] = 1'b1;
        seq_nxt = SQ_MC;
      end
      SQ_MC: begin
        mreq    = '{start: 1'b1, op: OP_MUL, a: {16'd0, chan_r}, b: bits_r};
        seq_nxt = SQ_MCW;
      end
      SQ_MCW: if (mrsp.done) begin
        if ({16'd0, align_r} != {3'b000, mrsp.res[31:3]}) warn_nxt[WRN_ALIGN] = 1'b1;
        seq_nxt = SQ_IDLE;
        seq_end = 1'b1;
      end
      SQ_DV: begin
        mreq    = '{start: 1'b1, op: OP_DIV, a: dsize_r, b: align_r};
        seq_nxt = SQ_DVW;
      end
      SQ_DVW: if (mrsp.done) begin
        quot_nxt = mrsp.res;
        seq_nxt  = SQ_IDLE;
        seq_end  = 1'b1;
      end
      default: seq_nxt = SQ_IDLE;
    endcase
  end

  assign ov_nxt = (ov_r && !out_ch.ready) || (accept && !fire_mul && !fire_div) || seq_end;

  wavhp_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FILE_TAG; idx_r <= '0; fs_r <= '0; swap_r <= 1'b0;
      riff_r <= '0; cons_r <= '0; fmtsz_r <= '0; fmtid_r <= '0;
      chan_r <= '0; rate_r <= '0; brate_r <= '0; align_r <= '0; bits_r <= '0;
      skip_r <= '0; dsize_r <= '0; prem_r <= '0; err_r <= ERR_NONE; warn_r <= '0;
      tag_r <= '0; gbad_r <= 1'b0;
      seq_r <= SQ_IDLE; ov_r <= 1'b0; quot_r <= '0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt; idx_r <= idx_nxt; fs_r <= fs_nxt; swap_r <= swap_nxt;
        riff_r <= riff_nxt; cons_r <= cons_nxt; fmtsz_r <= fmtsz_nxt; fmtid_r <= fmtid_nxt;
        chan_r <= chan_nxt; rate_r <= rate_nxt; brate_r <= brate_nxt;
        align_r <= align_nxt; bits_r <= bits_nxt;
        skip_r <= skip_nxt; dsize_r <= dsize_nxt; prem_r <= prem_nxt; err_r <= err_nxt;
        tag_r <= tag_nxt; gbad_r <= gbad_nxt;
      end
      warn_r <= warn_nxt;
      seq_r  <= seq_nxt;
      ov_r   <= ov_nxt;
      quot_r <= quot_nxt;
    end
    tmp_r <= tmp_nxt;
    if (accept) begin
      pv_r <= pv_nxt;
      pb_r <= pb_nxt;
      pl_r <= pl_nxt;
    end
  end

  // result fields read straight from the parser registers; they move on an input transaction,
  // which waits for the pending result to go, or (warnings, sample count) in the sequencer
  assign out_ch.valid         = ov_r;
  assign out_ch.payload_valid = pv_r;
  assign out_ch.payload_byte  = pb_r;
  assign out_ch.payload_last  = pl_r;
  assign out_ch.header_done   = (phase_r == PH_PAYLOAD);
  assign out_ch.error_code    = err_r;
  assign out_ch.warning_flags = warn_r;
  assign out_ch.big_endian    = swap_r;
  assign out_ch.num_channels  = chan_r;
  assign out_ch.samp_rate     = rate_r;
  assign out_ch.frame_bytes   = align_r;
  assign out_ch.stream_mode   = (phase_r == PH_PAYLOAD) && stream_reg;
  assign out_ch.sample_count  = (phase_r != PH_PAYLOAD) ? 33'sd0 :
                                stream_reg ? -33'sd1 : $signed({1'b0, quot_r});

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (seq_r == SQ_IDLE)) else $error("ready while sequencer busy");
  a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !fire_mul && !fire_div) |=> ov_r) else $error("result not posted");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE) |=> (err_r == $past(err_r))) else $error("error code changed");
  a_payload_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |=> (phase_r == PH_PAYLOAD)) else $error("left payload");

endmodule

// File: design/wavhp_mdu.sv
// ---------------------------------------------------------------------------
// wavhp_mdu
// Shared multiply (32x16, registered result) and radix-2 divide (32/16).
// ---------------------------------------------------------------------------
module wavhp_mdu
  import wavhp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mdu_req_t req,
  output mdu_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] d_r, d_nxt;
  logic [16:0] trial;
  logic [47:0] prod;

  assign prod  = req.a * req.b;
  assign trial = {rem_r[15:0], q_r[31]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      case (req.op)
        OP_MUL: begin
          q_nxt    = prod[31:0];
          done_nxt = 1'b1;
        end
        OP_DIV: begin
          q_nxt    = req.a;
          rem_nxt  = '0;
          d_nxt    = req.b;
          cnt_nxt  = '0;
          busy_nxt = 1'b1;
        end
        default: begin
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = q_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("mdu start while busy");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == 5'd31) |=> done_r) else $error("mdu divide did not finish");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("mdu done while busy");

endmodule
